@@ hw/rtl/icrc_pkg.sv @@
// ----------------------------------------------------------------------------
// icrc_pkg
// shared types, codes and helpers of the icmp probe reply classifier
// ----------------------------------------------------------------------------
package icrc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_ID = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_SEQ = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ECHO_REPLY_TYPE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIME_EXCEEDED_TYPE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SEND_TIME = 3'd4;

  localparam logic [7:0] ECHO_REPLY_TYPE_RST = 8'd0;
  localparam logic [7:0] TIME_EXCEEDED_TYPE_RST = 8'd11;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_OTHER_TYPE = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [2:0] FIELD_BYTES = 3'd4;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ECHO  = 2'd1,
    CLS_TE    = 2'd2
  } cls_e;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_seq;
    logic [7:0]  echo_reply_type;
    logic [7:0]  time_exceeded_type;
    logic [31:0] send_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reply_kind;
    logic [31:0] source_ip;
    logic [31:0] round_trip;
  } result_t;

  function automatic cls_e classify(input logic [7:0] kind, input cfg_t cfg);
    cls_e c;
    if (kind == cfg.echo_reply_type) begin
      c = CLS_ECHO;
    end else if (kind == cfg.time_exceeded_type) begin
      c = CLS_TE;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/icrc_parse.sv @@
// ----------------------------------------------------------------------------
// icrc_parse
// per-packet parse state: header walk, field capture and end-of-packet verdict
// ----------------------------------------------------------------------------
module icrc_parse import icrc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [31:0] now_time_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  localparam int unsigned OfsW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CmpW = OfsW + 2;
  localparam logic [OfsW-1:0] OfsMax = OfsW'(MAX_PACKET_BYTES);

  logic [OfsW-1:0] ofs_q, ofs_d;
  logic [5:0]      hdr_q, hdr_d;
  logic [7:0]      kind_q, kind_d;
  logic [7:0]      ino_q, ino_d;
  logic [31:0]     src_q, src_d;
  logic [15:0]     id_q, id_d;
  logic [15:0]     seq_q, seq_d;
  logic [2:0]      seen_q, seen_d;

  logic [CmpW-1:0] p_w, ino_w, len_w, hf_w;
  logic            cap_en;
  logic [1:0]      cap_k;
  cls_e            cls_cur, cls_fin;
  logic [1:0]      status;

  always_comb begin
    ofs_d   = ofs_q;
    hdr_d   = hdr_q;
    kind_d  = kind_q;
    ino_d   = ino_q;
    src_d   = src_q;
    id_d    = id_q;
    seq_d   = seq_q;
    seen_d  = seen_q;
    cap_en  = 1'b0;
    cap_k   = 2'd0;
    p_w     = CmpW'(ofs_q);
    ino_w   = CmpW'(ino_q);
    cls_cur = classify(kind_q, cfg_i);

    if (ofs_q < OfsMax) begin
      if (ofs_q == '0) begin
        hdr_d = {data_byte_i[3:0], 2'b00};
      end
      if (p_w >= CmpW'(12) && p_w <= CmpW'(15)) begin
        src_d = {src_q[23:0], data_byte_i};
      end
      if (p_w == CmpW'(hdr_d)) begin
        kind_d = data_byte_i;
      end
      if (p_w > CmpW'(hdr_d)) begin
        if (cls_cur == CLS_ECHO && p_w >= CmpW'(hdr_d) + CmpW'(4)
            && p_w <= CmpW'(hdr_d) + CmpW'(7)) begin
          cap_en = 1'b1;
          cap_k  = 2'(p_w - CmpW'(hdr_d) - CmpW'(4));
        end
        if (cls_cur == CLS_TE) begin
          if (p_w == CmpW'(hdr_d) + CmpW'(8)) begin
            ino_d = 8'(CmpW'(hdr_d) + CmpW'(8) + CmpW'({data_byte_i[3:0], 2'b00}));
          end
          if (p_w > CmpW'(hdr_d) + CmpW'(8) && p_w >= ino_w + CmpW'(4)
              && p_w <= ino_w + CmpW'(7)) begin
            cap_en = 1'b1;
            cap_k  = 2'(p_w - ino_w - CmpW'(4));
          end
        end
      end
      ofs_d = ofs_q + OfsW'(1);
    end

    if (cap_en) begin
      case (cap_k)
        2'd0:    id_d  = {data_byte_i, id_q[7:0]};
        2'd1:    id_d  = {id_q[15:8], data_byte_i};
        2'd2:    seq_d = {data_byte_i, seq_q[7:0]};
        default: seq_d = {seq_q[15:8], data_byte_i};
      endcase
      if (seen_q < FIELD_BYTES) begin
        seen_d = seen_q + 3'd1;
      end
    end
  end

  // end-of-packet verdict on the updated state
  always_comb begin
    len_w   = CmpW'(ofs_d);
    hf_w    = CmpW'(hdr_d);
    cls_fin = (len_w > hf_w) ? classify(kind_d, cfg_i) : CLS_OTHER;
    if (len_w < hf_w + CmpW'(8)) begin
      status = ST_TOO_SHORT;
    end else if (cls_fin == CLS_OTHER) begin
      status = ST_OTHER_TYPE;
    end else if (seen_d < FIELD_BYTES) begin
      status = ST_TOO_SHORT;
    end else if (id_d != cfg_i.expected_id || seq_d != cfg_i.expected_seq) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_ACCEPTED;
    end
    result_o.status     = status;
    result_o.reply_kind = (cls_fin == CLS_TE);
    result_o.source_ip  = src_d;
    result_o.round_trip = (status == ST_ACCEPTED) ? (now_time_i - cfg_i.send_time) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q  <= '0;
      hdr_q  <= '0;
      kind_q <= '0;
      ino_q  <= '0;
      src_q  <= '0;
      id_q   <= '0;
      seq_q  <= '0;
      seen_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        ofs_q  <= '0;
        hdr_q  <= '0;
        kind_q <= '0;
        ino_q  <= '0;
        src_q  <= '0;
        id_q   <= '0;
        seq_q  <= '0;
        seen_q <= '0;
      end else begin
        ofs_q  <= ofs_d;
        hdr_q  <= hdr_d;
        kind_q <= kind_d;
        ino_q  <= ino_d;
        src_q  <= src_d;
        id_q   <= id_d;
        seq_q  <= seq_d;
        seen_q <= seen_d;
      end
    end
  end

endmodule

@@ hw/rtl/icmp_probe_reply_classifier.sv @@
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Matches received IPv4 packets against an outstanding traceroute probe.
//
// The slave stream carries one packet byte per request, tlast on the final
// byte, and the current tick count beside each byte. The packet header length
// locates the ICMP header; echo replies and time-exceeded messages (through
// the embedded header) yield an id and sequence that are compared with the
// configured probe. One result request leaves on the master stream for each
// packet: status and reply kind in tuser, source address and round trip in
// tdata.
// Throughput is one byte per cycle while the master side does not stall. A
// byte passes an input register, then the parse logic, then the result
// register, which takes the result when the packet's last byte is consumed.
// When the master side stalls, the held result blocks the parse step, the
// input register stays full and tready drops in the same cycle, without
// losing a byte. Reset empties both registers, clears the parse state and
// loads the configuration defaults. Configuration is to be written only
// between packets; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier import icrc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // data_byte, now_time
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // source_ip, round_trip
  output logic [2:0]          m_axis_tuser    // status, reply_kind
);

  cfg_t        cfg_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic [31:0] in_now_q;
  logic        out_vld_q;
  result_t     out_res_q;
  result_t     res;
  logic        consume;

  assign consume       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id        <= '0;
      cfg_q.expected_seq       <= '0;
      cfg_q.echo_reply_type    <= ECHO_REPLY_TYPE_RST;
      cfg_q.time_exceeded_type <= TIME_EXCEEDED_TYPE_RST;
      cfg_q.send_time          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPECTED_ID:        cfg_q.expected_id        <= cfg_data_i[15:0];
        CFG_EXPECTED_SEQ:       cfg_q.expected_seq       <= cfg_data_i[15:0];
        CFG_ECHO_REPLY_TYPE:    cfg_q.echo_reply_type    <= cfg_data_i[7:0];
        CFG_TIME_EXCEEDED_TYPE: cfg_q.time_exceeded_type <= cfg_data_i[7:0];
        CFG_SEND_TIME:          cfg_q.send_time          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_now_q  <= s_axis_tdata[39:8];
      in_last_q <= s_axis_tlast;
    end
  end

  icrc_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (consume),
    .data_byte_i(in_byte_q),
    .last_i     (in_last_q),
    .now_time_i (in_now_q),
    .cfg_i      (cfg_q),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_res_q.round_trip, out_res_q.source_ip};
  assign m_axis_tuser  = {out_res_q.reply_kind, out_res_q.status};

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the icmp probe reply classifier.
//
// Packets are streamed byte by byte into the slave port. A behavioral parser
// in the bench follows each accepted byte and queues the status, reply kind,
// source address and round trip that the packet must yield. Every result
// request on the master port is compared against the oldest queued entry.
// Directed packets cover defaults, register extremes, short and other-type
// packets, tiny header lengths, equal type codes and oversized packets. The
// random part sends mostly well-formed echo replies and time-exceeded
// messages with random content, plus truncated and noise packets, under four
// mixes of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import icrc_pkg::*;

  localparam int PKT_MAX = 1024;
  localparam int SETTLE = 6;
  localparam int QUIET_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata = '0;   // data_byte, now_time
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;        // source_ip, round_trip
  logic [2:0]          m_axis_tuser;        // status, reply_kind

  icmp_probe_reply_classifier #(
    .MAX_PACKET_BYTES(PKT_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // probe settings as the parser sees them
  logic [15:0] want_id;
  logic [15:0] want_seq;
  logic [7:0]  echo_code;
  logic [7:0]  te_code;
  logic [31:0] sent_at;

  // per-packet parse state
  logic [10:0] pos;
  logic [5:0]  hdr_len;
  logic [7:0]  kind_byte;
  logic [7:0]  inner_off;
  logic [31:0] src_addr;
  logic [15:0] got_id;
  logic [15:0] got_seq;
  logic [2:0]  n_caught;

  result_t     pending_replies[$];
  logic [7:0]  pkt[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int quiet_cycles = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  function automatic void clear_parse();
    pos = '0;
    hdr_len = '0;
    kind_byte = '0;
    inner_off = '0;
    src_addr = '0;
    got_id = '0;
    got_seq = '0;
    n_caught = '0;
  endfunction

  function automatic cls_e kind_of(logic [7:0] t);
    if (t == echo_code) return CLS_ECHO;
    if (t == te_code) return CLS_TE;
    return CLS_OTHER;
  endfunction

  function automatic void take_field(int k, logic [7:0] b);
    case (k)
      0: got_id[15:8] = b;
      1: got_id[7:0] = b;
      2: got_seq[15:8] = b;
      default: got_seq[7:0] = b;
    endcase
    if (n_caught < FIELD_BYTES) n_caught++;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic lst, logic [31:0] now);
    int p;
    int h;
    int base;
    cls_e c;
    logic [1:0] st;
    result_t r;
    p = pos;
    if (p < PKT_MAX) begin
      if (p == 0) hdr_len = {b[3:0], 2'b00};
      h = hdr_len;
      if (p >= 12 && p <= 15) src_addr = {src_addr[23:0], b};
      if (p == h) kind_byte = b;
      if (p > h) begin
        c = kind_of(kind_byte);
        if (c == CLS_ECHO && p >= h + 4 && p <= h + 7) take_field(p - h - 4, b);
        if (c == CLS_TE) begin
          if (p == h + 8) inner_off = 8'(h + 8 + 4 * int'(b[3:0]));
          base = inner_off;
          if (p > h + 8 && p >= base + 4 && p <= base + 7) take_field(p - base - 4, b);
        end
      end
      pos = pos + 11'd1;
    end
    if (lst) begin
      p = pos;
      h = hdr_len;
      c = (p > h) ? kind_of(kind_byte) : CLS_OTHER;
      if (p < h + 8) st = ST_TOO_SHORT;
      else if (c == CLS_OTHER) st = ST_OTHER_TYPE;
      else if (n_caught < FIELD_BYTES) st = ST_TOO_SHORT;
      else if (got_id != want_id || got_seq != want_seq) st = ST_MISMATCH;
      else st = ST_ACCEPTED;
      r.status = st;
      r.reply_kind = (c == CLS_TE);
      r.source_ip = src_addr;
      r.round_trip = (st == ST_ACCEPTED) ? now - sent_at : 32'd0;
      pending_replies.push_back(r);
      status_seen[st]++;
      clear_parse();
    end
  endfunction

  task automatic check_reply();
    result_t exp;
    if (pending_replies.size() == 0) begin
      $error("result request with no packet pending: tuser %h tdata %h",
             m_axis_tuser, m_axis_tdata);
      errors++;
    end else begin
      exp = pending_replies.pop_front();
      if (m_axis_tuser[1:0] !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, m_axis_tuser[1:0]);
        errors++;
      end
      if (m_axis_tuser[2] !== exp.reply_kind) begin
        $error("reply_kind: expected %0d, got %0d", exp.reply_kind, m_axis_tuser[2]);
        errors++;
      end
      if (m_axis_tdata[31:0] !== exp.source_ip) begin
        $error("source_ip: expected %h, got %h", exp.source_ip, m_axis_tdata[31:0]);
        errors++;
      end
      if (m_axis_tdata[63:32] !== exp.round_trip) begin
        $error("round_trip: expected %h, got %h", exp.round_trip, m_axis_tdata[63:32]);
        errors++;
      end
    end
  endtask

  // result side and sink back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_reply();
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no request moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] now);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, b};
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, lst, now);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [31:0] stamp);
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte(pkt[i], i == pkt.size() - 1, (i == pkt.size() - 1) ? stamp : $urandom);
    end
    packets_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] id, input logic [15:0] seq,
                            input logic [7:0] echo_t, input logic [7:0] te_t,
                            input logic [31:0] st);
    logic [CfgIdxW-1:0] idx[5];
    logic [31:0] val[5];
    wait_idle();
    idx = '{CFG_EXPECTED_ID, CFG_EXPECTED_SEQ, CFG_ECHO_REPLY_TYPE,
            CFG_TIME_EXCEEDED_TYPE, CFG_SEND_TIME};
    // upper bits of the narrow registers carry junk
    val = '{{16'($urandom), id}, {16'($urandom), seq}, {24'($urandom), echo_t},
            {24'($urandom), te_t}, st};
    for (int i = 0; i < 5; i++) begin
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      cfg_we_i <= 1'b1;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    want_id = id;
    want_seq = seq;
    echo_code = echo_t;
    te_code = te_t;
    sent_at = st;
  endtask

  function automatic void put_byte(int i, logic [7:0] v);
    if (i < pkt.size()) pkt[i] = v;
  endfunction

  // len 0 gives the shortest packet that holds every field
  function automatic void build_packet(int ihl, logic [7:0] typ, bit te_shape, int inner_ihl,
                                       logic [15:0] id, logic [15:0] seq, int len);
    int h;
    int base;
    int full;
    h = ihl * 4;
    base = h + 8 + inner_ihl * 4;
    full = te_shape ? base + 8 : h + 8;
    if (len == 0) len = full;
    pkt.delete();
    for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
    put_byte(0, {4'h4, 4'(ihl)});
    put_byte(h, typ);
    if (te_shape) begin
      put_byte(h + 8, {4'h4, 4'(inner_ihl)});
      h = base;
    end
    put_byte(h + 4, id[15:8]);
    put_byte(h + 5, id[7:0]);
    put_byte(h + 6, seq[15:8]);
    put_byte(h + 7, seq[7:0]);
  endfunction

  task automatic test_defaults();
    build_packet(5, ECHO_REPLY_TYPE_RST, 1'b0, 5, 16'h0000, 16'h0000, 0);
    send_packet(32'h1234_5678);
    build_packet(5, TIME_EXCEEDED_TYPE_RST, 1'b1, 5, 16'h0000, 16'h0000, 0);
    send_packet(32'hFFFF_FFFF);
    build_packet(5, 8'd8, 1'b0, 5, 16'h0000, 16'h0000, 0);
    send_packet($urandom);
  endtask

  task automatic test_register_extremes();
    set_config(16'hFFFF, 16'h0000, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    build_packet(5, 8'hFF, 1'b0, 5, 16'hFFFF, 16'h0000, 0);
    send_packet(32'h0000_0000);
    build_packet(5, 8'hFF, 1'b0, 5, 16'hFFFE, 16'h0000, 4);
    send_packet($urandom);
    build_packet(15, 8'h00, 1'b1, 15, 16'hFFFF, 16'h0001, 0);
    send_packet($urandom);
    build_packet(15, 8'h00, 1'b1, 15, 16'hFFFF, 16'h0000, 3);
    send_packet(32'h7FFF_FFFF);
    build_packet(15, 8'hFF, 1'b0, 5, 16'hFFFF, 16'h0000, 0);
    send_packet(32'hFFFF_FFFE);
  endtask

  task automatic test_short_and_other();
    set_config(16'hA55A, 16'h5AA5, 8'd0, 8'd11, 32'h8000_0000);
    build_packet(5, 8'd0, 1'b0, 5, 16'hA55A, 16'h5AA5, 1);
    send_packet($urandom);
    build_packet(5, 8'd0, 1'b0, 5, 16'hA55A, 16'h5AA5, 27);
    send_packet($urandom);
    build_packet(5, 8'd11, 1'b1, 5, 16'hA55A, 16'h5AA5, 55);
    send_packet($urandom);
    build_packet(6, 8'd3, 1'b0, 5, 16'hA55A, 16'h5AA5, 31);
    send_packet($urandom);
    build_packet(6, 8'd3, 1'b0, 5, 16'hA55A, 16'h5AA5, 32);
    send_packet($urandom);
  endtask

  task automatic test_small_headers();
    set_config(16'h0102, 16'h0304, 8'h40, 8'h41, 32'd100);
    for (int ihl = 0; ihl < 5; ihl++) begin
      build_packet(ihl, 8'h40, 1'b0, 5, 16'h0102, 16'h0304, 24);
      send_packet(32'd150);
    end
    build_packet(1, 8'h41, 1'b1, 0, 16'h0102, 16'h0304, 0);
    send_packet(32'd99);
    // identical type codes: echo reply wins
    set_config(16'h0102, 16'h0304, 8'd11, 8'd11, 32'd100);
    build_packet(5, 8'd11, 1'b1, 5, 16'h0102, 16'h0304, 0);
    send_packet(32'd200);
    build_packet(5, 8'd11, 1'b0, 5, 16'h0102, 16'h0304, 0);
    send_packet(32'd200);
  endtask

  // bytes past the size limit are dropped and the count stays at the limit
  task automatic test_long_packets();
    set_config(16'h1111, 16'h2222, 8'd0, 8'd11, 32'd5);
    build_packet(5, 8'd11, 1'b1, 5, 16'h1111, 16'h2222, PKT_MAX + 2);
    send_packet(32'd4);
  endtask

  task automatic random_packet();
    int sel;
    int ihl;
    int inner;
    int full;
    int len;
    bit te_shape;
    logic [7:0] typ;
    logic [15:0] id;
    logic [15:0] seq;
    logic [31:0] stamp;
    sel = $urandom_range(99);
    ihl = (sel < 70) ? 5 : (sel < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    inner = ($urandom_range(99) < 80) ? 5 : $urandom_range(0, 15);
    sel = $urandom_range(99);
    if (sel < 40) begin
      typ = echo_code;
      te_shape = 1'b0;
    end else if (sel < 80) begin
      typ = te_code;
      te_shape = 1'b1;
    end else begin
      typ = 8'($urandom);
      te_shape = 1'($urandom);
    end
    id = want_id;
    seq = want_seq;
    sel = $urandom_range(99);
    if (sel < 10) id = 16'($urandom);
    else if (sel < 20) seq ^= 16'(1 << $urandom_range(15));
    else if (sel < 25) id ^= 16'(1 << $urandom_range(15));
    full = te_shape ? ihl * 4 + 16 + inner * 4 : ihl * 4 + 8;
    sel = $urandom_range(99);
    if (sel < 80) len = full + $urandom_range(0, 8);
    else if (sel < 92) len = $urandom_range(1, full - 1);
    else len = full + $urandom_range(9, 40);
    build_packet(ihl, typ, te_shape, inner, id, seq, len);
    sel = $urandom_range(99);
    if (sel < 5) stamp = sent_at;
    else if (sel < 10) stamp = sent_at - 32'd1;
    else stamp = $urandom;
    send_packet(stamp);
  endtask

  task automatic test_random_traffic(input int sidle, input int rstall);
    int first_byte;
    int n;
    idle_pct = sidle;
    stall_pct = rstall;
    first_byte = bytes_sent;
    n = 0;
    while (bytes_sent - first_byte < 60 || n < 3) begin
      random_packet();
      n++;
      // source holds off until the sink has drained everything
      if (n % 3 == 2) wait_idle();
    end
  endtask

  initial begin
    want_id = '0;
    want_seq = '0;
    echo_code = ECHO_REPLY_TYPE_RST;
    te_code = TIME_EXCEEDED_TYPE_RST;
    sent_at = '0;
    clear_parse();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_register_extremes();
    test_short_and_other();
    test_small_headers();
    test_long_packets();

    set_config(16'($urandom), 16'($urandom), 8'd0, 8'd11, $urandom);
    test_random_traffic(0, 0);
    set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    test_random_traffic(51, 0);
    set_config(16'h0000, 16'h0000, 8'h81, 8'h7E, 32'h0000_0000);
    test_random_traffic(0, 51);
    set_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    test_random_traffic(7, 7);

    idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    $display("covered %0d packets (%0d bytes) over four source/sink idle mixes",
             packets_sent, bytes_sent);
    $display("outcomes: %0d accepted, %0d too short, %0d other type, %0d id/seq mismatch",
             status_seen[ST_ACCEPTED], status_seen[ST_TOO_SHORT],
             status_seen[ST_OTHER_TYPE], status_seen[ST_MISMATCH]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/icrc_pkg.sv
hw/rtl/icrc_parse.sv
hw/rtl/icmp_probe_reply_classifier.sv
sim/tb.sv
